/* rtl/ncqp_pkg.sv */
// ----------------------------------------------------------------------------
// NVMe completion queue poller package
// Shared codes, constants and the job word passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package ncqp_pkg;

  // Default sizes.
  localparam int unsigned QueueDepthDefault = 64;
  localparam int unsigned JobQueueDepthDefault = 4;

  // Reset value of the retry delay register.
  localparam logic [31:0] RetryDelayReset = 32'd3000000;

  // Bytes per logical block, as a shift.
  localparam int unsigned BlockBytesShift = 12;

  // Input operation codes.
  localparam logic [1:0] OpPoll  = 2'd0;
  localparam logic [1:0] OpEntry = 2'd1;
  localparam logic [1:0] OpTick  = 2'd2;
  localparam logic [1:0] OpResp  = 2'd3;

  // Output word kinds.
  localparam logic [2:0] KindFetch     = 3'd0;
  localparam logic [2:0] KindDoorbell  = 3'd1;
  localparam logic [2:0] KindSqHead    = 3'd2;
  localparam logic [2:0] KindTableReq  = 3'd3;
  localparam logic [2:0] KindByteTotal = 3'd4;

  // Job classes handed from front to back.
  typedef enum logic [1:0] {
    JobFetch,
    JobCompletion,
    JobTotal
  } job_kind_e;

  // One job: what the back part needs to emit its output words.
  typedef struct packed {
    job_kind_e   kind;
    logic [5:0]  queue_index;
    logic [15:0] sq_head;
    logic [15:0] cid;
    logic [63:0] count;
    logic [63:0] bytes;
  } job_t;

endpackage

`default_nettype wire

/* rtl/ncqp_front.sv */
// ----------------------------------------------------------------------------
// NVMe completion queue poller front
// Accepts input words, runs the polling state and pushes one job per result.
// ----------------------------------------------------------------------------
`default_nettype none

module ncqp_front #(
  parameter int unsigned QUEUE_DEPTH = ncqp_pkg::QueueDepthDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [31:0]     cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [1:0]      op_i,
  input  wire logic            entry_phase_i,
  input  wire logic [15:0]     entry_sq_head_i,
  input  wire logic [15:0]     entry_cid_i,
  input  wire logic [15:0]     blocks_minus_one_i,
  input  wire logic            job_full_i,
  output logic                 job_push_o,
  output ncqp_pkg::job_t       job_o
);
  import ncqp_pkg::*;

  localparam int unsigned HeadW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Mode codes.
  localparam logic [1:0] ModeIdle  = 2'd0;
  localparam logic [1:0] ModeEntry = 2'd1;
  localparam logic [1:0] ModeDelay = 2'd2;
  localparam logic [1:0] ModeResp  = 2'd3;

  logic [31:0]      retry_q;
  logic [1:0]       mode_q, mode_d;
  logic [HeadW-1:0] head_q, head_d;
  logic             phase_q, phase_d;
  logic [31:0]      wait_q, wait_d;
  logic [63:0]      count_q, count_d;
  logic [63:0]      bytes_q, bytes_d;
  logic [HeadW:0]   head_inc;
  logic [31:0]      wait_inc;
  logic             accept;

  // Every word is taken while the job queue has room.
  assign in_ready_o = !job_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign head_inc = {1'b0, head_q} + {{HeadW{1'b0}}, 1'b1};
  assign wait_inc = wait_q + 32'd1;

  // Classify the word against the current mode and build its job.
  always_comb begin
    mode_d     = mode_q;
    head_d     = head_q;
    phase_d    = phase_q;
    wait_d     = wait_q;
    count_d    = count_q;
    bytes_d    = bytes_q;
    job_push_o = 1'b0;
    job_o.kind        = JobFetch;
    job_o.queue_index = 6'(head_q);
    job_o.sq_head     = entry_sq_head_i;
    job_o.cid         = entry_cid_i;
    job_o.count       = count_q;
    job_o.bytes       = bytes_q;
    if (accept) begin
      case (op_i)
        OpPoll: begin
          if (mode_q == ModeIdle) begin
            mode_d     = ModeEntry;
            job_push_o = 1'b1;
          end
        end
        OpEntry: begin
          if (mode_q == ModeEntry) begin
            if (entry_phase_i == phase_q) begin
              // Entry not yet new: restart the wait.
              wait_d = 32'd0;
              mode_d = ModeDelay;
            end else begin
              if (head_inc >= (HeadW+1)'(QUEUE_DEPTH)) begin
                head_d  = '0;
                phase_d = !phase_q;
              end else begin
                head_d = head_inc[HeadW-1:0];
              end
              count_d           = count_q + 64'd1;
              mode_d            = ModeResp;
              job_push_o        = 1'b1;
              job_o.kind        = JobCompletion;
              job_o.queue_index = 6'(head_d);
              job_o.count       = count_d;
            end
          end
        end
        OpTick: begin
          if (mode_q == ModeDelay) begin
            if (wait_inc == retry_q) begin
              wait_d     = 32'd0;
              mode_d     = ModeEntry;
              job_push_o = 1'b1;
            end else begin
              wait_d = wait_inc;
            end
          end
        end
        OpResp: begin
          if (mode_q == ModeResp) begin
            bytes_d     = bytes_q
                          + (({48'd0, blocks_minus_one_i} + 64'd1) << BlockBytesShift);
            mode_d      = ModeIdle;
            job_push_o  = 1'b1;
            job_o.kind  = JobTotal;
            job_o.bytes = bytes_d;
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end
  end

  // Polling state and configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q <= RetryDelayReset;
      mode_q  <= ModeIdle;
      head_q  <= '0;
      phase_q <= 1'b0;
      wait_q  <= 32'd0;
      count_q <= 64'd0;
      bytes_q <= 64'd0;
    end else begin
      if (cfg_we_i) begin
        retry_q <= cfg_wdata_i;
      end
      mode_q  <= mode_d;
      head_q  <= head_d;
      phase_q <= phase_d;
      wait_q  <= wait_d;
      count_q <= count_d;
      bytes_q <= bytes_d;
    end
  end

  // The count moves only on a completion job.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_d != count_q) |-> (job_push_o && job_o.kind == JobCompletion))
    else $error("completion count changed without a completion job");

  // A byte total job always returns the block to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_push_o && job_o.kind == JobTotal) |=> (mode_q == ModeIdle))
    else $error("byte total job did not return to idle");

  // Nothing is pushed while the job queue is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_full_i |-> !job_push_o)
    else $error("job pushed into a full queue");

endmodule

`default_nettype wire

/* rtl/ncqp_fifo.sv */
// ----------------------------------------------------------------------------
// NVMe completion queue poller job queue
// Short first-in first-out queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ncqp_fifo #(
  parameter int unsigned DEPTH = ncqp_pkg::JobQueueDepthDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ncqp_pkg::job_t  push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output ncqp_pkg::job_t       pop_data_o
);
  import ncqp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            slots_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            do_push, do_pop;

  assign full_o     = (fill_q == CntW'(DEPTH));
  assign valid_o    = (fill_q != '0);
  assign pop_data_o = slots_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Fill level never runs past the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(DEPTH))
    else $error("job queue fill above depth");

  // A push alone raises the fill level by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (fill_q == $past(fill_q) + CntW'(1)))
    else $error("job queue fill not raised on push");

  // Read and write pointers agree when the queue is empty or full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0 || full_o) |-> (rd_ptr_q == wr_ptr_q))
    else $error("job queue pointers disagree with fill level");

endmodule

`default_nettype wire

/* rtl/ncqp_back.sv */
// ----------------------------------------------------------------------------
// NVMe completion queue poller back
// Turns each job into one or three output words through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ncqp_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            job_valid_i,
  input  wire ncqp_pkg::job_t  job_i,
  output logic                 job_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [2:0]           kind_o,
  output logic [5:0]           queue_index_o,
  output logic [15:0]          sq_head_out_o,
  output logic [15:0]          request_cid_o,
  output logic [63:0]          completed_count_o,
  output logic [63:0]          completed_bytes_o,
  output logic                 last_o
);
  import ncqp_pkg::*;

  // Word position within a completion job.
  localparam logic [1:0] BeatDoorbell = 2'd0;
  localparam logic [1:0] BeatSqHead   = 2'd1;
  localparam logic [1:0] BeatTable    = 2'd2;

  logic [1:0]  beat_q, beat_d;
  logic        out_valid_q, out_valid_d;
  logic        load;
  logic [2:0]  kind_d;
  logic [5:0]  qidx_d;
  logic [15:0] sqh_d;
  logic [15:0] cid_d;
  logic        last_d;

  // Load a new word when the output register is free or being emptied.
  assign load = job_valid_i && (!out_valid_q || out_ready_i);

  // Select the next word for the job at the queue head.
  always_comb begin
    beat_d    = beat_q;
    job_pop_o = 1'b0;
    kind_d    = KindFetch;
    qidx_d    = 6'd0;
    sqh_d     = 16'd0;
    cid_d     = 16'd0;
    last_d    = 1'b1;
    case (job_i.kind)
      JobFetch: begin
        kind_d = KindFetch;
        qidx_d = job_i.queue_index;
        job_pop_o = load;
      end
      JobCompletion: begin
        case (beat_q)
          BeatDoorbell: begin
            kind_d = KindDoorbell;
            qidx_d = job_i.queue_index;
            last_d = 1'b0;
            if (load) begin
              beat_d = BeatSqHead;
            end
          end
          BeatSqHead: begin
            kind_d = KindSqHead;
            sqh_d  = job_i.sq_head;
            last_d = 1'b0;
            if (load) begin
              beat_d = BeatTable;
            end
          end
          default: begin
            kind_d    = KindTableReq;
            cid_d     = job_i.cid;
            job_pop_o = load;
            if (load) begin
              beat_d = BeatDoorbell;
            end
          end
        endcase
      end
      default: begin
        kind_d    = KindByteTotal;
        job_pop_o = load;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= BeatDoorbell;
      out_valid_q <= 1'b0;
    end else begin
      beat_q      <= beat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_o            <= kind_d;
      queue_index_o     <= qidx_d;
      sq_head_out_o     <= sqh_d;
      request_cid_o     <= cid_d;
      completed_count_o <= job_i.count;
      completed_bytes_o <= job_i.bytes;
      last_o            <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A doorbell word is never the last of its group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KindDoorbell) |-> !last_o)
    else $error("doorbell word marked last");

  // A taken doorbell word is followed at once by the sq head word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && kind_o == KindDoorbell)
      |=> (out_valid_o && kind_o == KindSqHead))
    else $error("sq head word did not follow doorbell");

  // A table request word always closes its group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KindTableReq) |-> last_o)
    else $error("table request word not marked last");

endmodule

`default_nettype wire

/* rtl/nvme_completion_queue_poller_unit.sv */
// ----------------------------------------------------------------------------
// NVMe completion queue poller
// Host-side completion queue consumer with phase-tag polling.
// ----------------------------------------------------------------------------
// The block takes one input word per clock cycle while its job queue has room.
// Words that do not fit the current mode are taken and dropped. A poll, retry
// or table response gives one output word; a new completion entry gives three
// output words (doorbell, sq head, table request) in order, so its cost is
// set by the output side. The front classifies words and updates state in
// the cycle a word is taken; a four-job queue feeds the back, which drives
// an output register. Input ready falls only while that job queue is full.
`default_nettype none

module nvme_completion_queue_poller_unit #(
  parameter int unsigned QUEUE_DEPTH     = ncqp_pkg::QueueDepthDefault,
  parameter int unsigned JOB_QUEUE_DEPTH = ncqp_pkg::JobQueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic        entry_phase_i,
  input  wire logic [15:0] entry_sq_head_i,
  input  wire logic [15:0] entry_cid_i,
  input  wire logic [15:0] blocks_minus_one_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       kind_o,
  output logic [5:0]       queue_index_o,
  output logic [15:0]      sq_head_out_o,
  output logic [15:0]      request_cid_o,
  output logic [63:0]      completed_count_o,
  output logic [63:0]      completed_bytes_o,
  output logic             last_o
);
  import ncqp_pkg::*;

  job_t push_job;
  job_t head_job;
  logic job_push;
  logic job_full;
  logic job_valid;
  logic job_pop;

  // Front: classification and polling state.
  ncqp_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .entry_phase_i     (entry_phase_i),
    .entry_sq_head_i   (entry_sq_head_i),
    .entry_cid_i       (entry_cid_i),
    .blocks_minus_one_i(blocks_minus_one_i),
    .job_full_i        (job_full),
    .job_push_o        (job_push),
    .job_o             (push_job)
  );

  // Job queue between front and back.
  ncqp_fifo #(
    .DEPTH(JOB_QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_push),
    .push_data_i(push_job),
    .full_o     (job_full),
    .pop_i      (job_pop),
    .valid_o    (job_valid),
    .pop_data_o (head_job)
  );

  // Back: output word generation.
  ncqp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (job_valid),
    .job_i            (head_job),
    .job_pop_o        (job_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .queue_index_o    (queue_index_o),
    .sq_head_out_o    (sq_head_out_o),
    .request_cid_o    (request_cid_o),
    .completed_count_o(completed_count_o),
    .completed_bytes_o(completed_bytes_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NVMe completion queue poller testbench
// Drives poll, entry, tick and table response words into the poller. A
// predictor mirrors the poller state, queues the output words each accepted
// word should cause, and a checker compares every output word field by field.
// ----------------------------------------------------------------------------

module tb_top;
  import ncqp_pkg::*;

  localparam int unsigned QUEUE_DEPTH = QueueDepthDefault;
  // Output words can trail the last expected one by the job queue and output
  // register; this many cycles covers that with margin.
  localparam int SETTLE_CYCLES = 16;
  localparam int WORDS_PER_PHASE = 90;

  typedef enum logic [1:0] {
    ModeIdle,
    ModeAwaitEntry,
    ModeDelay,
    ModeAwaitResp
  } poll_mode_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  queue_index;
    logic [15:0] sq_head;
    logic [15:0] cid;
    logic [63:0] count;
    logic [63:0] bytes;
    logic        last;
  } poller_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = OpPoll;
  logic        entry_phase_i = 1'b0;
  logic [15:0] entry_sq_head_i = '0;
  logic [15:0] entry_cid_i = '0;
  logic [15:0] blocks_minus_one_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  kind_o;
  logic [5:0]  queue_index_o;
  logic [15:0] sq_head_out_o;
  logic [15:0] request_cid_o;
  logic [63:0] completed_count_o;
  logic [63:0] completed_bytes_o;
  logic        last_o;

  // Predicted poller state.
  poll_mode_e  poll_mode = ModeIdle;
  logic [15:0] head_q = '0;
  logic        phase_q = 1'b0;
  logic [31:0] tick_count = '0;
  logic [31:0] retry_delay_q = RetryDelayReset;
  logic [63:0] count_q = '0;
  logic [63:0] bytes_q = '0;

  // Output words still owed by the poller, oldest first.
  poller_word_t pending_words[$];

  int errors = 0;
  int words_acted = 0;
  int words_dropped = 0;
  int words_checked = 0;
  int stale_entries = 0;
  int retries = 0;
  int cfg_writes = 0;
  bit quiet = 1'b0;

  nvme_completion_queue_poller_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .entry_phase_i     (entry_phase_i),
    .entry_sq_head_i   (entry_sq_head_i),
    .entry_cid_i       (entry_cid_i),
    .blocks_minus_one_i(blocks_minus_one_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .queue_index_o     (queue_index_o),
    .sq_head_out_o     (sq_head_out_o),
    .request_cid_o     (request_cid_o),
    .completed_count_o (completed_count_o),
    .completed_bytes_o (completed_bytes_o),
    .last_o            (last_o)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Queue one expected output word, stamped with the current totals.
  function automatic void push_word(logic [2:0] kind, logic [5:0] qidx, logic [15:0] sqh,
                                    logic [15:0] cid, logic last);
    poller_word_t w;
    w.kind = kind;
    w.queue_index = qidx;
    w.sq_head = sqh;
    w.cid = cid;
    w.count = count_q;
    w.bytes = bytes_q;
    w.last = last;
    pending_words.push_back(w);
  endfunction

  // Advance the predicted poller by one accepted word and queue its outputs.
  function automatic void predict_poller_words(logic [1:0] op, logic phase, logic [15:0] sqh,
                                               logic [15:0] cid, logic [15:0] nlb);
    bit dropped;
    dropped = 1'b0;
    case (op)
      OpPoll: begin
        if (poll_mode != ModeIdle) begin
          dropped = 1'b1;
        end else begin
          poll_mode = ModeAwaitEntry;
          push_word(KindFetch, head_q[5:0], '0, '0, 1'b1);
        end
      end
      OpEntry: begin
        if (poll_mode != ModeAwaitEntry) begin
          dropped = 1'b1;
        end else if (phase == phase_q) begin
          // The entry is not new yet: start the retry countdown.
          tick_count = '0;
          poll_mode = ModeDelay;
          stale_entries++;
        end else begin
          if (head_q == 16'(QUEUE_DEPTH - 1)) begin
            head_q = '0;
            phase_q = ~phase_q;
          end else begin
            head_q = head_q + 16'd1;
          end
          count_q = count_q + 64'd1;
          poll_mode = ModeAwaitResp;
          push_word(KindDoorbell, head_q[5:0], '0, '0, 1'b0);
          push_word(KindSqHead, '0, sqh, '0, 1'b0);
          push_word(KindTableReq, '0, '0, cid, 1'b1);
        end
      end
      OpTick: begin
        if (poll_mode != ModeDelay) begin
          dropped = 1'b1;
        end else begin
          tick_count = tick_count + 32'd1;
          if (tick_count == retry_delay_q) begin
            tick_count = '0;
            poll_mode = ModeAwaitEntry;
            retries++;
            push_word(KindFetch, head_q[5:0], '0, '0, 1'b1);
          end
        end
      end
      default: begin
        if (poll_mode != ModeAwaitResp) begin
          dropped = 1'b1;
        end else begin
          bytes_q = bytes_q + ((64'(nlb) + 64'd1) << BlockBytesShift);
          poll_mode = ModeIdle;
          push_word(KindByteTotal, '0, '0, '0, 1'b1);
        end
      end
    endcase
    if (dropped) words_dropped++;
    else words_acted++;
  endfunction

  // Send one input word after an optional gap and predict once it is taken.
  task automatic send_word(input logic [1:0] op, input logic phase, input logic [15:0] sqh,
                           input logic [15:0] cid, input logic [15:0] nlb);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    entry_phase_i <= phase;
    entry_sq_head_i <= sqh;
    entry_cid_i <= cid;
    blocks_minus_one_i <= nlb;
    do @(posedge clk_i); while (!in_ready_o);
    predict_poller_words(op, phase, sqh, cid, nlb);
  endtask

  // Write the retry delay once the poller has nothing left in flight.
  task automatic write_retry_delay(input logic [31:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    retry_delay_q = value;
    cfg_writes++;
  endtask

  // Compare one field of an output word.
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Check every output word against the oldest expectation.
  always @(posedge clk_i) begin : check_output_words
    poller_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected output word, expected none, actual kind %0d", $time, kind_o);
      end else begin
        want = pending_words.pop_front();
        check_field("kind", 64'(want.kind), 64'(kind_o));
        check_field("queue_index", 64'(want.queue_index), 64'(queue_index_o));
        check_field("sq_head_out", 64'(want.sq_head), 64'(sq_head_out_o));
        check_field("request_cid", 64'(want.cid), 64'(request_cid_o));
        check_field("completed_count", want.count, completed_count_o);
        check_field("completed_bytes", want.bytes, completed_bytes_o);
        check_field("last", 64'(want.last), 64'(last_o));
        words_checked++;
      end
    end
  end

  // Output side: runs of ready, sometimes long, broken by stalls.
  initial begin : drive_out_ready
    int run;
    int gap;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      repeat (run - 1) @(negedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  end

  // Two full completions with all-zero and all-one fields.
  task automatic test_first_completions();
    write_retry_delay(32'd1);
    send_word(OpPoll, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_word(OpEntry, ~phase_q, 16'h0000, 16'h0000, 16'h0000);
    send_word(OpResp, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_word(OpPoll, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(OpEntry, ~phase_q, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(OpResp, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
  endtask

  // In each mode, words of the other operations must be dropped.
  task automatic test_out_of_mode_words();
    send_word(OpEntry, ~phase_q, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpTick, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpResp, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpPoll, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpPoll, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpTick, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpResp, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    // A stale entry moves the poller to the retry countdown.
    send_word(OpEntry, phase_q, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpPoll, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpEntry, ~phase_q, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpResp, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpTick, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpEntry, ~phase_q, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpPoll, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpEntry, ~phase_q, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpTick, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpResp, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Largest and zero retry delay. Each countdown is ended by setting the delay
  // above the ticks already counted: lowered from the largest, raised from zero.
  task automatic test_retry_delay_extremes();
    write_retry_delay(32'hFFFF_FFFF);
    send_word(OpPoll, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpEntry, phase_q, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpTick, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpTick, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    write_retry_delay(32'd3);
    send_word(OpTick, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
    write_retry_delay(32'd0);
    send_word(OpEntry, phase_q, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpTick, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpTick, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
    write_retry_delay(32'd4);
    send_word(OpTick, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpTick, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpEntry, ~phase_q, 16'($urandom), 16'($urandom), 16'($urandom));
    send_word(OpResp, 1'b1, 16'($urandom), 16'($urandom), 16'h8000);
  endtask

  // Mostly the word the current mode expects, with random content and
  // some stale entries; about one word in ten is random noise.
  task automatic send_random_word();
    logic [1:0]  op;
    logic        phase;
    logic [15:0] sqh;
    logic [15:0] cid;
    logic [15:0] nlb;
    op = 2'($urandom_range(0, 3));
    phase = 1'($urandom_range(0, 1));
    sqh = 16'($urandom);
    cid = 16'($urandom);
    nlb = 16'($urandom);
    if ($urandom_range(0, 99) >= 10) begin
      case (poll_mode)
        ModeIdle: op = OpPoll;
        ModeAwaitEntry: begin
          op = OpEntry;
          phase = ($urandom_range(0, 99) < 30) ? phase_q : ~phase_q;
        end
        ModeDelay: op = OpTick;
        default: op = OpResp;
      endcase
    end
    send_word(op, phase, sqh, cid, nlb);
  endtask

  // Random traffic in several phases, each with its own retry delay.
  task automatic test_random_traffic();
    logic [31:0] delay;
    int target;
    int n;
    n = 0;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: delay = 32'd1;
        1: delay = 32'($urandom_range(2, 6));
        2: delay = 32'($urandom_range(1, 3));
        default: delay = 32'd7;
      endcase
      // Never drop the delay to or below a countdown already under way.
      if (poll_mode == ModeDelay && delay <= tick_count) delay = tick_count + 32'd2;
      write_retry_delay(delay);
      target = words_acted + WORDS_PER_PHASE;
      while (words_acted < target) begin
        if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        send_random_word();
        n++;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_first_completions();
    test_out_of_mode_words();
    test_retry_delay_extremes();
    test_random_traffic();

    // Let the last output words drain, then watch for strays.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d words (%0d dropped out of mode), checked %0d output words.",
             words_acted + words_dropped, words_dropped, words_checked);
    $display("Completions %0d, stale entries %0d, retries %0d, delay writes %0d, errors %0d.",
             count_q, stale_entries, retries, cfg_writes, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d output words still expected.", pending_words.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
